[design/assert_macros.svh]
// Assertion macros shared by the echo reply tracker RTL.
// Each macro expects clk and arst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ERT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define ERT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/ert_pkg.sv]
// Types and constants of the echo reply tracker.
// No dependencies; used by the interfaces and all modules.
`default_nettype none

package ert_pkg;

	localparam int SEQ_W   = 16;
	localparam int CNT_W   = 32;
	localparam int TRIP_W  = 32;
	localparam int SUM_W   = 64;

	typedef logic [2:0] status_t;

	localparam status_t ST_SENT      = 3'd0;
	localparam status_t ST_SHORT     = 3'd1;
	localparam status_t ST_NOT_OURS  = 3'd2;
	localparam status_t ST_NEW_REPLY = 3'd3;
	localparam status_t ST_DUPLICATE = 3'd4;
	localparam status_t ST_OWN_ECHO  = 3'd5;
	localparam status_t ST_OTHER     = 3'd6;

	localparam logic CMD_TX = 1'b0;
	localparam logic CMD_RX = 1'b1;

	localparam logic [7:0] ICMP_ECHO_REPLY   = 8'd0;
	localparam logic [7:0] ICMP_ECHO_REQUEST = 8'd8;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_MY_IDENT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LEN = 2'd1;

	localparam logic [15:0] PAYLOAD_LEN_RST = 16'd56;
	localparam int ICMP_HDR_BYTES = 8;
	localparam int STAMP_MIN_BYTES = 12;

	// Result queue sizing
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic        command;
		logic [15:0] packet_len;
		logic [3:0]  header_words;
		logic [7:0]  msg_type;
		logic [15:0] icmp_ident;
		logic [15:0] seq_in;
		logic [31:0] sent_stamp;
		logic [31:0] now_us;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] seq_out;
		logic [31:0] trip_time;
		logic        time_valid;
		logic [31:0] sent_total;
		logic [31:0] received_total;
		logic [31:0] duplicate_total;
		logic [31:0] min_trip;
		logic [31:0] max_trip;
		logic [63:0] trip_sum;
	} result_t;

	// Window memory port; slots are cut to the window's index width inside
	typedef struct packed {
		logic             rd_en;
		logic [SEQ_W-1:0] rd_slot;
		logic             wr_en;
		logic [SEQ_W-1:0] wr_slot;
		logic             wr_bit;
	} seen_req_t;

endpackage

`default_nettype wire

[design/ert_if.sv]
// Handshake channels of the echo reply tracker: items, results, config writes.
// Depends on ert_pkg for the payload types.
`default_nettype none

interface ert_item_if;
	logic           valid;
	logic           ready;
	ert_pkg::item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ert_result_if;
	logic             valid;
	logic             ready;
	ert_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ert_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [ert_pkg::CFG_IDX_W-1:0]  index;
	logic [15:0]                    wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

[design/ert_slot_calc.sv]
// Two-stage window slot calculation: sequence modulo the window size.
// Uses a reciprocal multiply and a back multiply; depends on ert_pkg.
`default_nettype none

module ert_slot_calc #(
	parameter int DUP_WINDOW = 1024
) (
	input  logic                            clk,
	input  logic [ert_pkg::SEQ_W-1:0]       seq,
	output logic [$clog2(DUP_WINDOW)-1:0]   slot
);
	import ert_pkg::*;

	localparam int SW    = $clog2(DUP_WINDOW);
	localparam int SHIFT = SEQ_W + SW;
	localparam longint unsigned RECIP =
		((64'd1 << SHIFT) + longint'(DUP_WINDOW) - 64'd1) / longint'(DUP_WINDOW);
	localparam int RW = $clog2(RECIP + 1);
	localparam int PW = SEQ_W + RW;

	logic [PW-1:0]    prod_s1;
	logic [SEQ_W-1:0] seq_s1;
	logic [SEQ_W-1:0] quot;
	logic [SEQ_W-1:0] qd_s2;
	logic [SEQ_W-1:0] seq_s2;

	// quotient is exact for all 16-bit inputs with this reciprocal and shift
	assign quot = SEQ_W'(prod_s1 >> SHIFT);

	always_ff @(posedge clk) begin
		prod_s1 <= PW'(seq) * PW'(RECIP);
		seq_s1  <= seq;
		qd_s2   <= SEQ_W'(32'(quot) * 32'(DUP_WINDOW));
		seq_s2  <= seq_s1;
	end

	assign slot = SW'(seq_s2 - qd_s2);

endmodule

`default_nettype wire

[design/ert_seen_map.sv]
// Duplicate window bitmap: one-bit memory with a registered read.
// Sweeps itself clear after reset; depends on ert_pkg for the port struct.
`default_nettype none

module ert_seen_map #(
	parameter int DUP_WINDOW = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ert_pkg::seen_req_t    req,
	output logic                  rd_bit,
	output logic                  busy
);
	import ert_pkg::*;

	localparam int SW = $clog2(DUP_WINDOW);

	logic          mem [DUP_WINDOW];
	logic          busy_q;
	logic [SW-1:0] clr_idx_q;
	logic          rd_bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_idx_q <= '0;
		end else if (busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == SW'(DUP_WINDOW - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_idx_q] <= 1'b0;
		end else if (req.wr_en) begin
			mem[req.wr_slot[SW-1:0]] <= req.wr_bit;
		end
		if (req.rd_en) begin
			rd_bit_q <= mem[req.rd_slot[SW-1:0]];
		end
	end

	assign rd_bit = rd_bit_q;
	assign busy   = busy_q;

endmodule

`default_nettype wire

[design/ert_result_fifo.sv]
// Result queue in front of the output channel, eight entries of registers.
// Depends on ert_pkg and the result channel interface.
`default_nettype none

module ert_result_fifo (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  ert_pkg::result_t                  push_data,
	output logic [ert_pkg::FIFO_CNT_W-1:0]    count,
	ert_result_if.source                      result
);
	import ert_pkg::*;

	result_t               mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  pop;

	assign pop = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign result.valid = (count_q != '0);
	assign result.data  = mem_q[rd_ptr_q];
	assign count        = count_q;

endmodule

`default_nettype wire

[design/echo_reply_tracker.sv]
// Echo reply tracker: takes one transmit or receive transaction per clock
// while not held off by the bitmap clear or by result queue credit, and
// returns one result per transaction, in order. The duplicate window bitmap
// lives in a memory with a registered read; each reply reads its slot at
// stage two and writes it back at stage three (transmits clear theirs), and
// the last write is forwarded so back-to-back hits on one slot see each other.
// After reset the bitmap is swept clear; items wait, config writes do not.
// An eight-entry result queue lets items keep flowing while results wait.
// Depends on ert_pkg, ert_if, ert_slot_calc, ert_seen_map, ert_result_fifo.
`default_nettype none
`include "assert_macros.svh"

module echo_reply_tracker #(
	parameter int DUP_WINDOW = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	ert_item_if.sink       item,
	ert_result_if.source   result,
	ert_cfg_if.sink        cfg
);
	import ert_pkg::*;

	localparam int SW = $clog2(DUP_WINDOW);

	// configuration
	logic [15:0] my_ident_q;
	logic [15:0] payload_len_q;

	// accept stage
	logic             accept;
	logic             is_tx;
	logic             too_short;
	logic             stamp_ok;
	logic [SEQ_W-1:0] seq0;
	status_t          status0;
	logic             reply0;
	logic [15:0]      tx_seq_q;

	// pipeline
	logic             v_s1, v_s2, v_s3;
	logic             is_tx_s1, is_tx_s2, is_tx_s3;
	logic             reply_s1, reply_s2, reply_s3;
	logic             stamp_ok_s1, stamp_ok_s2, stamp_ok_s3;
	status_t          status_s1, status_s2, status_s3;
	logic [SEQ_W-1:0] seq_s1, seq_s2, seq_s3;
	logic [31:0]      stamp_s1, now_s1;
	logic [31:0]      trip_s2, trip_s3;
	logic [SW-1:0]    slot;
	logic [SW-1:0]    slot_s3;

	// window memory and forwarding
	seen_req_t     mem_req;
	logic          rd_bit;
	logic          clr_busy;
	logic          fwd_vld_q;
	logic [SW-1:0] fwd_slot_q;
	logic          fwd_bit_q;
	logic          seen;

	// statistics
	logic [31:0] sent_q, recv_q, dup_q, min_q, max_q;
	logic [63:0] sum_q;
	logic [31:0] sent_nx, recv_nx, dup_nx, min_nx, max_nx;
	logic [63:0] sum_nx;
	logic        time_valid;
	result_t     res;

	// result queue credit
	logic [FIFO_CNT_W-1:0] fifo_cnt;
	logic [FIFO_CNT_W:0]   load;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			my_ident_q    <= '0;
			payload_len_q <= PAYLOAD_LEN_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_MY_IDENT:    my_ident_q    <= cfg.wdata;
				CFG_PAYLOAD_LEN: payload_len_q <= cfg.wdata;
				default: ;
			endcase
		end
	end

	// hold back items while the queue cannot absorb everything in flight
	assign load = (FIFO_CNT_W+1)'(fifo_cnt) + (FIFO_CNT_W+1)'(v_s1)
		+ (FIFO_CNT_W+1)'(v_s2) + (FIFO_CNT_W+1)'(v_s3);
	assign item.ready = !clr_busy && (load < (FIFO_CNT_W+1)'(FIFO_DEPTH));
	assign accept = item.valid && item.ready;

	assign is_tx = (item.data.command == CMD_TX);
	assign seq0  = is_tx ? tx_seq_q : item.data.seq_in;
	assign too_short = {1'b0, item.data.packet_len}
		< ({1'b0, payload_len_q} + 17'(ICMP_HDR_BYTES));
	assign stamp_ok = {1'b0, item.data.packet_len}
		>= ({11'b0, item.data.header_words, 2'b00} + 17'(STAMP_MIN_BYTES));

	always_comb begin
		reply0 = 1'b0;
		if (is_tx) begin
			status0 = ST_SENT;
		end else if (too_short) begin
			status0 = ST_SHORT;
		end else if (item.data.icmp_ident != my_ident_q) begin
			status0 = ST_NOT_OURS;
		end else if (item.data.msg_type == ICMP_ECHO_REPLY) begin
			status0 = ST_NEW_REPLY;
			reply0  = 1'b1;
		end else if (item.data.msg_type == ICMP_ECHO_REQUEST) begin
			status0 = ST_OWN_ECHO;
		end else begin
			status0 = ST_OTHER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_seq_q <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
		end else begin
			if (accept && is_tx) begin
				tx_seq_q <= tx_seq_q + 1'b1;
			end
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		is_tx_s1    <= is_tx;
		reply_s1    <= reply0;
		stamp_ok_s1 <= stamp_ok;
		status_s1   <= status0;
		seq_s1      <= seq0;
		stamp_s1    <= item.data.sent_stamp;
		now_s1      <= item.data.now_us;

		is_tx_s2    <= is_tx_s1;
		reply_s2    <= reply_s1;
		stamp_ok_s2 <= stamp_ok_s1;
		status_s2   <= status_s1;
		seq_s2      <= seq_s1;
		trip_s2     <= now_s1 - stamp_s1;

		is_tx_s3    <= is_tx_s2;
		reply_s3    <= reply_s2;
		stamp_ok_s3 <= stamp_ok_s2;
		status_s3   <= status_s2;
		seq_s3      <= seq_s2;
		trip_s3     <= trip_s2;
		slot_s3     <= slot;
	end

	ert_slot_calc #(
		.DUP_WINDOW (DUP_WINDOW)
	) u_slot (
		.clk  (clk),
		.seq  (seq0),
		.slot (slot)
	);

	// read at stage two, write back at stage three
	always_comb begin
		mem_req.rd_en   = v_s2;
		mem_req.rd_slot = SEQ_W'(slot);
		mem_req.wr_en   = v_s3 && (is_tx_s3 || reply_s3);
		mem_req.wr_slot = SEQ_W'(slot_s3);
		mem_req.wr_bit  = reply_s3;
	end

	ert_seen_map #(
		.DUP_WINDOW (DUP_WINDOW)
	) u_seen (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rd_bit (rd_bit),
		.busy   (clr_busy)
	);

	// the previous write lands after this item's read was taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
		end else begin
			fwd_vld_q <= mem_req.wr_en;
		end
	end

	always_ff @(posedge clk) begin
		fwd_slot_q <= slot_s3;
		fwd_bit_q  <= reply_s3;
	end

	assign seen = (fwd_vld_q && (fwd_slot_q == slot_s3)) ? fwd_bit_q : rd_bit;
	assign time_valid = reply_s3 && stamp_ok_s3;

	always_comb begin
		sent_nx = sent_q;
		recv_nx = recv_q;
		dup_nx  = dup_q;
		min_nx  = min_q;
		max_nx  = max_q;
		sum_nx  = sum_q;
		if (is_tx_s3) begin
			sent_nx = sent_q + 32'd1;
		end
		if (reply_s3) begin
			if (seen) begin
				dup_nx = dup_q + 32'd1;
			end else begin
				recv_nx = recv_q + 32'd1;
			end
		end
		if (time_valid) begin
			sum_nx = sum_q + 64'(trip_s3);
			if (trip_s3 < min_q) begin
				min_nx = trip_s3;
			end
			if (trip_s3 > max_q) begin
				max_nx = trip_s3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q <= '0;
			recv_q <= '0;
			dup_q  <= '0;
			min_q  <= '1;
			max_q  <= '0;
			sum_q  <= '0;
		end else if (v_s3) begin
			sent_q <= sent_nx;
			recv_q <= recv_nx;
			dup_q  <= dup_nx;
			min_q  <= min_nx;
			max_q  <= max_nx;
			sum_q  <= sum_nx;
		end
	end

	always_comb begin
		res.status          = reply_s3 ? (seen ? ST_DUPLICATE : ST_NEW_REPLY) : status_s3;
		res.seq_out         = seq_s3;
		res.trip_time       = time_valid ? trip_s3 : 32'd0;
		res.time_valid      = time_valid;
		res.sent_total      = sent_nx;
		res.received_total  = recv_nx;
		res.duplicate_total = dup_nx;
		res.min_trip        = min_nx;
		res.max_trip        = max_nx;
		res.trip_sum        = sum_nx;
	end

	ert_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s3),
		.push_data (res),
		.count     (fifo_cnt),
		.result    (result)
	);

	`ERT_ASSERT(a_tx_seq_tracks_count, v_s3 && is_tx_s3 |-> seq_s3 == sent_q[15:0], "transmit sequence out of step with send count")
	`ERT_ASSERT(a_queue_credit, load <= (FIFO_CNT_W+1)'(FIFO_DEPTH), "more items in flight than result queue entries")
	`ERT_ASSERT(a_clear_idle, clr_busy |-> !(v_s1 || v_s2 || v_s3), "item in flight during bitmap clear")
	`ERT_ASSERT(a_slot_range, v_s2 |-> {1'b0, slot} < (SW+1)'(DUP_WINDOW), "window slot beyond window size")
	`ERT_ASSERT_NEXT(a_reply_marks, v_s3 && reply_s3, fwd_vld_q && fwd_bit_q, "reply did not mark its window slot")

endmodule

`default_nettype wire
